// ----- hw/rtl/adam_opt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Adam optimiser package
// Word types of both channels, register map and fixed-point constants.
// ----------------------------------------------------------------------------
package adam_opt_pkg;

  // Input word: one parameter element
  typedef struct packed {
    logic [11:0]        elem_index;
    logic signed [31:0] grad;
    logic signed [31:0] param_value;
    logic               step_start;
  } in_t;

  // Output word: the updated element
  typedef struct packed {
    logic [11:0]        out_index;
    logic signed [31:0] new_param;
  } out_t;

  // Register map, word index on the configuration port
  typedef enum logic [1:0] {
    REG_BETA_FIRST  = 2'd0,
    REG_BETA_SECOND = 2'd1,
    REG_LEARN_RATE  = 2'd2,
    REG_EPSILON     = 2'd3
  } cfg_reg_e;

  // Register reset values
  localparam logic [15:0] BETA_FIRST_RST  = 16'd58982;
  localparam logic [15:0] BETA_SECOND_RST = 16'd65470;
  localparam logic [23:0] LEARN_RATE_RST  = 24'd16777;
  localparam logic [23:0] EPSILON_RST     = 24'd1;

  // 1.0 in Q2.30 and Q1.16
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
  localparam logic [16:0] ONE_Q16 = 17'h1_0000;

  // Update magnitude ceiling, 2^40
  localparam logic [40:0] UPD_CAP = 41'h100_0000_0000;

endpackage

`default_nettype wire

// ----- hw/rtl/adam_optimizer_update.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Adam optimiser element update
// Streams parameter elements through a moment update, bias correction,
// square root and division, one element per clock when not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_stall_o/in_data_i carries one element word:
//   index, gradient, current value and the step start flag. Output channel
//   out_valid_o/out_stall_i/out_data_o returns the updated value and index.
//   Registers (beta_first, beta_second, learn_rate, epsilon) sit on the APB
//   port at byte addresses 0, 4, 8 and 12; write them only while idle.
// Throughput: one word per cycle when not stalled, also with repeated indices; the
//   moment read-modify-write is one pipeline stage with forwarding of the last write.
// Path: from the accepting edge to out_valid_o a word passes stages A to D, the
//   two 62-stage bias-correction dividers, the 32-stage square root, stages E to
//   G, the 41-stage update divider and the output register.
// Reset: powers return to 1.0, registers to their defaults, and a clearing
//   pass zeroes both moment memories, one entry per cycle, over all ELEMENTS entries;
//   in_stall_o stays high until it is done.
// Stall: while out_stall_i holds a waiting word the whole pipeline freezes
//   and in_stall_o is high; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module adam_optimizer_update #(
  parameter int unsigned ELEMENTS = 4096
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire adam_opt_pkg::in_t  in_data_i,
  // output channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output adam_opt_pkg::out_t      out_data_o,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  import adam_opt_pkg::*;

  localparam int unsigned AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [15:0] beta1_q, beta2_q;
  logic [23:0] lr_q, eps_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta1_q <= BETA_FIRST_RST;
      beta2_q <= BETA_SECOND_RST;
      lr_q    <= LEARN_RATE_RST;
      eps_q   <= EPSILON_RST;
    end else if (cfg_wr) begin
      case (cfg_reg_e'(paddr[3:2]))
        REG_BETA_FIRST:  beta1_q <= pwdata[15:0];
        REG_BETA_SECOND: beta2_q <= pwdata[15:0];
        REG_LEARN_RATE:  lr_q    <= pwdata[23:0];
        REG_EPSILON:     eps_q   <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_e'(paddr[3:2]))
      REG_BETA_FIRST:  prdata = {16'b0, beta1_q};
      REG_BETA_SECOND: prdata = {16'b0, beta2_q};
      REG_LEARN_RATE:  prdata = {8'b0, lr_q};
      REG_EPSILON:     prdata = {8'b0, eps_q};
      default:         prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline control: everything advances unless a finished word is held
  // --------------------------------------------------------------------------
  logic   en;
  logic   accept;
  logic   clr_busy_q;
  logic   out_vld_q;
  out_t   out_q;

  assign en         = ~(out_vld_q & out_stall_i);
  assign in_stall_o = ~en | clr_busy_q;
  assign accept     = in_valid_i & ~in_stall_o;

  // --------------------------------------------------------------------------
  // Decay powers, updated at the accepting edge of a step start
  // --------------------------------------------------------------------------
  logic [31:0] pw1_q, pw2_q, pw1_d, pw2_d;
  logic [47:0] pw1_mul, pw2_mul;
  logic [30:0] bc1_in, bc2_in;

  assign pw1_mul = 48'(pw1_q) * 48'(beta1_q);
  assign pw2_mul = 48'(pw2_q) * 48'(beta2_q);
  assign pw1_d   = in_data_i.step_start ? pw1_mul[47:16] : pw1_q;
  assign pw2_d   = in_data_i.step_start ? pw2_mul[47:16] : pw2_q;

  // zero correction counts as unity: divide by 1.0
  assign bc1_in = (pw1_d >= ONE_Q30) ? ONE_Q30[30:0] : 31'(ONE_Q30 - pw1_d);
  assign bc2_in = (pw2_d >= ONE_Q30) ? ONE_Q30[30:0] : 31'(ONE_Q30 - pw2_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw1_q <= ONE_Q30;
      pw2_q <= ONE_Q30;
    end else if (accept) begin
      pw1_q <= pw1_d;
      pw2_q <= pw2_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: input word; gradient square, first moment gradient term
  // --------------------------------------------------------------------------
  logic               a_vld_q;
  in_t                a_item_q;
  logic [30:0]        a_bc1_q, a_bc2_q;
  logic [31:0]        a_gmag;
  logic [63:0]        a_sq;
  logic signed [49:0] a_pm;
  logic [16:0]        b1c, b2c;
  logic [11:0]        a_rpart;

  assign b1c    = ONE_Q16 - {1'b0, beta1_q};
  assign b2c    = ONE_Q16 - {1'b0, beta2_q};
  assign a_gmag = a_item_q.grad[31] ? 32'(-a_item_q.grad) : a_item_q.grad;
  assign a_sq   = 64'(a_gmag) * 64'(a_gmag);
  assign a_pm   = $signed({1'b0, b1c}) * a_item_q.grad;

  // index modulo ELEMENTS, upper half of the reduction
  always_comb begin
    a_rpart = a_item_q.elem_index;
    for (int k = 11; k >= 6; k--) begin
      if (64'(a_rpart) >= (64'(ELEMENTS) << k)) begin
        a_rpart = a_rpart - 12'(64'(ELEMENTS) << k);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_item_q <= in_data_i;
      a_bc1_q  <= bc1_in;
      a_bc2_q  <= bc2_in;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: saturated square, second moment gradient term, memory address
  // --------------------------------------------------------------------------
  logic               b_vld_q;
  logic [11:0]        b_idx_q, b_rpart_q;
  logic signed [31:0] b_param_q;
  logic signed [49:0] b_pm_q;
  logic [63:0]        b_sq_q;
  logic [30:0]        b_bc1_q, b_bc2_q;
  logic [31:0]        b_gsq;
  logic [48:0]        b_pv;
  logic [11:0]        b_rmod;
  logic [AW-1:0]      b_addr;

  assign b_gsq = (|b_sq_q[63:56]) ? '1 : b_sq_q[55:24];
  assign b_pv  = 49'(b2c) * 49'(b_gsq);

  // index modulo ELEMENTS, lower half of the reduction
  always_comb begin
    b_rmod = b_rpart_q;
    for (int k = 5; k >= 0; k--) begin
      if (64'(b_rmod) >= (64'(ELEMENTS) << k)) begin
        b_rmod = b_rmod - 12'(64'(ELEMENTS) << k);
      end
    end
  end

  assign b_addr = AW'(b_rmod);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_idx_q   <= a_item_q.elem_index;
      b_param_q <= a_item_q.param_value;
      b_rpart_q <= a_rpart;
      b_pm_q    <= a_pm;
      b_sq_q    <= a_sq;
      b_bc1_q   <= a_bc1_q;
      b_bc2_q   <= a_bc2_q;
    end
  end

  // --------------------------------------------------------------------------
  // Moment memories with clearing pass; read at B->C, write at C->D
  // --------------------------------------------------------------------------
  logic [31:0]   mem_m [ELEMENTS];
  logic [31:0]   mem_v [ELEMENTS];
  logic [31:0]   rd_m_q, rd_v_q;
  logic [AW-1:0] clr_cnt_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [31:0]   mem_wm, mem_wv;

  logic               c_vld_q;
  logic [AW-1:0]      c_addr_q;
  logic [31:0]        c_m_new, c_v_new;

  assign mem_we = clr_busy_q | (en & c_vld_q);
  assign mem_wa = clr_busy_q ? clr_cnt_q : c_addr_q;
  assign mem_wm = clr_busy_q ? '0 : c_m_new;
  assign mem_wv = clr_busy_q ? '0 : c_v_new;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_m[mem_wa] <= mem_wm;
      mem_v[mem_wa] <= mem_wv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rd_m_q <= mem_m[b_addr];
      rd_v_q <= mem_v[b_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == AW'(ELEMENTS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: moment update, last write forwarded to the following word
  // --------------------------------------------------------------------------
  logic [11:0]        c_idx_q;
  logic signed [31:0] c_param_q;
  logic signed [49:0] c_pm_q;
  logic [48:0]        c_pv_q;
  logic [30:0]        c_bc1_q, c_bc2_q;
  logic               fwd_vld_q;
  logic [AW-1:0]      fwd_addr_q;
  logic [31:0]        fwd_m_q, fwd_v_q;
  logic               fwd_hit;
  logic signed [31:0] m_old;
  logic [31:0]        v_old;
  logic signed [49:0] c_msum;
  logic [49:0]        c_vsum;

  assign fwd_hit = fwd_vld_q & (fwd_addr_q == c_addr_q);
  assign m_old   = fwd_hit ? fwd_m_q : rd_m_q;
  assign v_old   = fwd_hit ? fwd_v_q : rd_v_q;
  assign c_msum  = $signed({1'b0, beta1_q}) * m_old + c_pm_q;
  assign c_vsum  = 50'(beta2_q) * 50'(v_old) + 50'(c_pv_q);
  assign c_m_new = c_msum[47:16];
  assign c_v_new = c_vsum[47:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q   <= 1'b0;
      fwd_vld_q <= 1'b0;
    end else if (en) begin
      c_vld_q <= b_vld_q;
      if (c_vld_q) begin
        fwd_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_idx_q   <= b_idx_q;
      c_param_q <= b_param_q;
      c_addr_q  <= b_addr;
      c_pm_q    <= b_pm_q;
      c_pv_q    <= b_pv;
      c_bc1_q   <= b_bc1_q;
      c_bc2_q   <= b_bc2_q;
      if (c_vld_q) begin
        fwd_addr_q <= c_addr_q;
        fwd_m_q    <= c_m_new;
        fwd_v_q    <= c_v_new;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage D: new moments; feed the bias-correction dividers
  // --------------------------------------------------------------------------
  logic               d_vld_q;
  logic [11:0]        d_idx_q;
  logic signed [31:0] d_param_q;
  logic [31:0]        d_m_q, d_v_q;
  logic [30:0]        d_bc1_q, d_bc2_q;
  logic               d_neg;
  logic [31:0]        d_mmag;

  assign d_neg  = d_m_q[31];
  assign d_mmag = d_neg ? 32'(-d_m_q) : d_m_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else if (en) begin
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_idx_q   <= c_idx_q;
      d_param_q <= c_param_q;
      d_m_q     <= c_m_new;
      d_v_q     <= c_v_new;
      d_bc1_q   <= c_bc1_q;
      d_bc2_q   <= c_bc2_q;
    end
  end

  // m_hat = |m| * 2^30 / bc1 and v_hat = v * 2^30 / bc2
  logic        mdiv_vld, vdiv_vld;
  logic [61:0] mhat, vhat;
  logic [12:0] mdiv_side;
  logic [31:0] vdiv_side;

  adam_opt_div #(.QW(62), .DW(31), .SW(13)) u_mdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (d_vld_q),
    .rem_i  ('0),
    .num_i  ({d_mmag, 30'b0}),
    .den_i  (d_bc1_q),
    .side_i ({d_idx_q, d_neg}),
    .vld_o  (mdiv_vld),
    .quo_o  (mhat),
    .side_o (mdiv_side)
  );

  adam_opt_div #(.QW(62), .DW(31), .SW(32)) u_vdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (d_vld_q),
    .rem_i  ('0),
    .num_i  ({d_v_q, 30'b0}),
    .den_i  (d_bc2_q),
    .side_i (d_param_q),
    .vld_o  (vdiv_vld),
    .quo_o  (vhat),
    .side_o (vdiv_side)
  );

  // --------------------------------------------------------------------------
  // Square root: small v_hat scaled up by 2^24, large one scaled after
  // --------------------------------------------------------------------------
  logic         big;
  logic [63:0]  sq_x;
  logic         sq_vld;
  logic [31:0]  sq_root;
  logic [107:0] sq_side;

  assign big  = |vhat[61:40];
  assign sq_x = big ? {2'b00, vhat} : {vhat[39:0], 24'b0};

  adam_opt_sqrt #(.SW(108)) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (mdiv_vld & vdiv_vld),
    .x_i    (sq_x),
    .side_i ({big, mhat, mdiv_side, vdiv_side}),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  // sideband fields after the root
  logic               s_big;
  logic [61:0]        s_mhat;
  logic [11:0]        s_idx;
  logic               s_neg;
  logic signed [31:0] s_param;

  assign s_big   = sq_side[107];
  assign s_mhat  = sq_side[106:45];
  assign s_idx   = sq_side[44:33];
  assign s_neg   = sq_side[32];
  assign s_param = sq_side[31:0];

  // --------------------------------------------------------------------------
  // Stage E: denominator, partial products of lr * m_hat
  // --------------------------------------------------------------------------
  logic               e_vld_q;
  logic [43:0]        e_den_q;
  logic [54:0]        e_plo_q, e_phi_q;
  logic [11:0]        e_idx_q;
  logic               e_neg_q;
  logic signed [31:0] e_param_q;
  logic [43:0]        e_root;

  assign e_root = s_big ? {sq_root, 12'b0} : {12'b0, sq_root};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (en) begin
      e_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_den_q   <= e_root + 44'(eps_q);
      e_plo_q   <= 55'(lr_q) * 55'(s_mhat[30:0]);
      e_phi_q   <= 55'(lr_q) * 55'(s_mhat[61:31]);
      e_idx_q   <= s_idx;
      e_neg_q   <= s_neg;
      e_param_q <= s_param;
    end
  end

  // --------------------------------------------------------------------------
  // Stage F: full product
  // --------------------------------------------------------------------------
  logic               f_vld_q;
  logic [85:0]        f_prod_q;
  logic [43:0]        f_den_q;
  logic [11:0]        f_idx_q;
  logic               f_neg_q;
  logic signed [31:0] f_param_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (en) begin
      f_vld_q <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_prod_q  <= 86'(e_plo_q) + (86'(e_phi_q) << 31);
      f_den_q   <= e_den_q;
      f_idx_q   <= e_idx_q;
      f_neg_q   <= e_neg_q;
      f_param_q <= e_param_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage G: ceiling check; a quotient of 2^40 or more saturates
  // --------------------------------------------------------------------------
  logic               g_vld_q;
  logic [43:0]        g_rem_q, g_den_q;
  logic [40:0]        g_num_q;
  logic [11:0]        g_idx_q;
  logic               g_neg_q, g_zero_q, g_over_q;
  logic signed [31:0] g_param_q;
  logic               f_over;

  assign f_over = (f_prod_q[85:40] >= {2'b00, f_den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q <= 1'b0;
    end else if (en) begin
      g_vld_q <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_rem_q   <= f_over ? '0 : f_prod_q[84:41];
      g_num_q   <= f_prod_q[40:0];
      g_den_q   <= f_den_q;
      g_over_q  <= f_over;
      g_zero_q  <= (f_den_q == '0);
      g_idx_q   <= f_idx_q;
      g_neg_q   <= f_neg_q;
      g_param_q <= f_param_q;
    end
  end

  // update magnitude = lr * m_hat / d
  logic        udiv_vld;
  logic [40:0] udiv_quo;
  logic [46:0] udiv_side;

  adam_opt_div #(.QW(41), .DW(44), .SW(47)) u_udiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (g_vld_q),
    .rem_i  (g_rem_q),
    .num_i  (g_num_q),
    .den_i  (g_den_q),
    .side_i ({g_idx_q, g_param_q, g_neg_q, g_zero_q, g_over_q}),
    .vld_o  (udiv_vld),
    .quo_o  (udiv_quo),
    .side_o (udiv_side)
  );

  // --------------------------------------------------------------------------
  // Output stage: apply update against the sign of m, saturate to 32 bits
  // --------------------------------------------------------------------------
  logic [11:0]        u_idx;
  logic signed [31:0] u_param;
  logic               u_neg, u_zero, u_over;
  logic [40:0]        upd;
  logic signed [42:0] res;
  logic signed [31:0] res_sat;

  assign u_idx   = udiv_side[46:35];
  assign u_param = udiv_side[34:3];
  assign u_neg   = udiv_side[2];
  assign u_zero  = udiv_side[1];
  assign u_over  = udiv_side[0];

  assign upd = u_zero ? '0 : (u_over ? UPD_CAP : udiv_quo);
  assign res = u_neg ? ({{11{u_param[31]}}, u_param} + $signed({2'b00, upd}))
                     : ({{11{u_param[31]}}, u_param} - $signed({2'b00, upd}));

  always_comb begin
    if (!res[42] && (|res[41:31])) begin
      res_sat = 32'sh7FFF_FFFF;
    end else if (res[42] && !(&res[41:31])) begin
      res_sat = 32'sh8000_0000;
    end else begin
      res_sat = res[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= udiv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.out_index <= u_idx;
      out_q.new_param <= res_sat;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- hw/rtl/adam_opt_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Adam optimiser pipelined divider
// Restoring division, one quotient bit per register stage, with a sideband
// word that travels alongside. The start remainder must be below the divisor.
// ----------------------------------------------------------------------------
module adam_opt_div #(
  parameter int unsigned QW = 62,
  parameter int unsigned DW = 31,
  parameter int unsigned SW = 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          vld_i,
  input  wire logic [DW-1:0] rem_i,
  input  wire logic [QW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [SW-1:0] side_i,
  output logic               vld_o,
  output logic      [QW-1:0] quo_o,
  output logic      [SW-1:0] side_o
);

  logic          vld_q  [QW];
  logic [DW-1:0] rem_q  [QW];
  logic [QW-1:0] nq_q   [QW];
  logic [DW-1:0] den_q  [QW];
  logic [SW-1:0] side_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          p_vld;
    logic [DW-1:0] p_rem;
    logic [QW-1:0] p_nq;
    logic [DW-1:0] p_den;
    logic [SW-1:0] p_side;
    logic [DW:0]   t;
    logic          ge;

    if (k == 0) begin : g_first
      assign p_vld  = vld_i;
      assign p_rem  = rem_i;
      assign p_nq   = num_i;
      assign p_den  = den_i;
      assign p_side = side_i;
    end else begin : g_next
      assign p_vld  = vld_q[k-1];
      assign p_rem  = rem_q[k-1];
      assign p_nq   = nq_q[k-1];
      assign p_den  = den_q[k-1];
      assign p_side = side_q[k-1];
    end

    // bring down the next dividend bit and try the subtraction
    assign t  = {p_rem, p_nq[QW-1]};
    assign ge = (t >= {1'b0, p_den});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= p_vld;
      end
    end

    // dividend bits leave at the top, quotient bits enter at the bottom
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? DW'(t - {1'b0, p_den}) : t[DW-1:0];
        nq_q[k]   <= {p_nq[QW-2:0], ge};
        den_q[k]  <= p_den;
        side_q[k] <= p_side;
      end
    end
  end

  assign vld_o  = vld_q[QW-1];
  assign quo_o  = nq_q[QW-1];
  assign side_o = side_q[QW-1];

endmodule

`default_nettype wire

// ----- hw/rtl/adam_opt_sqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Adam optimiser pipelined square root
// Floor square root of a 64-bit value, one root bit per register stage,
// with a sideband word that travels alongside.
// ----------------------------------------------------------------------------
module adam_opt_sqrt #(
  parameter int unsigned SW = 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          vld_i,
  input  wire logic [63:0]   x_i,
  input  wire logic [SW-1:0] side_i,
  output logic               vld_o,
  output logic      [31:0]   root_o,
  output logic      [SW-1:0] side_o
);

  localparam int unsigned NSTG = 32;

  logic          vld_q  [NSTG];
  logic [63:0]   x_q    [NSTG];
  logic [32:0]   rem_q  [NSTG];
  logic [31:0]   root_q [NSTG];
  logic [SW-1:0] side_q [NSTG];

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    logic          p_vld;
    logic [63:0]   p_x;
    logic [32:0]   p_rem;
    logic [31:0]   p_root;
    logic [SW-1:0] p_side;
    logic [34:0]   t;
    logic [34:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign p_vld  = vld_i;
      assign p_x    = x_i;
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_side = side_i;
    end else begin : g_next
      assign p_vld  = vld_q[k-1];
      assign p_x    = x_q[k-1];
      assign p_rem  = rem_q[k-1];
      assign p_root = root_q[k-1];
      assign p_side = side_q[k-1];
    end

    // next bit pair against 4r+1
    assign t     = {p_rem, p_x[63:62]};
    assign trial = {1'b0, p_root, 2'b01};
    assign ge    = (t >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= p_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k]    <= {p_x[61:0], 2'b00};
        rem_q[k]  <= ge ? 33'(t - trial) : t[32:0];
        root_q[k] <= {p_root[30:0], ge};
        side_q[k] <= p_side;
      end
    end
  end

  assign vld_o  = vld_q[NSTG-1];
  assign root_o = root_q[NSTG-1];
  assign side_o = side_q[NSTG-1];

endmodule

`default_nettype wire
